// ===== rtl/core/sgsa_pkg.sv =====
package sgsa_pkg;

    localparam int ANGLE_W = 8;
    localparam int TIMER_W = 24;
    localparam int STEP_W  = 8;
    localparam int OP_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [ANGLE_W-1:0] MAX_ANGLE   = 8'd180;
    localparam logic [TIMER_W-1:0] TIMER_MAX   = {TIMER_W{1'b1}};
    localparam logic [STEP_W-1:0]  STEP_MAX    = {STEP_W{1'b1}};

    // register reset values
    localparam logic [ANGLE_W-1:0] RST_OPEN_ANGLE   = 8'd90;
    localparam logic [ANGLE_W-1:0] RST_CLOSED_ANGLE = 8'd0;
    localparam logic [TIMER_W-1:0] RST_CLOSE_DELAY  = 24'd5000;
    localparam logic               RST_CLOSE_EN     = 1'b1;
    localparam logic [STEP_W-1:0]  RST_STEP_IVL     = 8'd15;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 3'd0,
        OP_OPEN  = 3'd1,
        OP_CLOSE = 3'd2,
        OP_MOVE  = 3'd3,
        OP_STOP  = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_ANGLE   = 3'd0,
        CFG_CLOSED_ANGLE = 3'd1,
        CFG_CLOSE_DELAY  = 3'd2,
        CFG_CLOSE_EN     = 3'd3,
        CFG_STEP_IVL     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [ANGLE_W-1:0] open_angle;
        logic [ANGLE_W-1:0] closed_angle;
        logic [TIMER_W-1:0] auto_close_delay;
        logic               auto_close_enable;
        logic [STEP_W-1:0]  step_interval;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [ANGLE_W-1:0] angle_request;
    } t_cmd;

    typedef struct packed {
        logic [ANGLE_W-1:0] servo_angle;
        logic               angle_written;
        logic               gate_open;
        logic               in_motion;
        logic               auto_closed;
    } t_result;

    function automatic logic [ANGLE_W-1:0] sat_angle(input logic [ANGLE_W-1:0] a);
        sat_angle = (a > MAX_ANGLE) ? MAX_ANGLE : a;
    endfunction

endpackage

// ===== rtl/core/sgsa_if.sv =====
interface sgsa_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [sgsa_pkg::OP_W-1:0]    operation;
    logic [sgsa_pkg::ANGLE_W-1:0] angle_request;

    modport source (output valid, output operation, output angle_request, input ready);
    modport sink   (input valid, input operation, input angle_request, output ready);
endinterface

interface sgsa_res_if;
    logic                        valid;
    logic                        ready;
    logic [sgsa_pkg::ANGLE_W-1:0] servo_angle;
    logic                        angle_written;
    logic                        gate_open;
    logic                        in_motion;
    logic                        auto_closed;

    modport source (output valid, output servo_angle, output angle_written,
                    output gate_open, output in_motion, output auto_closed,
                    input ready);
    modport sink   (input valid, input servo_angle, input angle_written,
                    input gate_open, input in_motion, input auto_closed,
                    output ready);
endinterface

// ===== rtl/core/sgsa_cfg_regs.sv =====
module sgsa_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sgsa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sgsa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output sgsa_pkg::t_cfg                    o_cfg
);
    import sgsa_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OPEN_ANGLE:   n_cfg.open_angle   = sat_angle(i_cfg_data[ANGLE_W-1:0]);
                CFG_CLOSED_ANGLE: n_cfg.closed_angle = sat_angle(i_cfg_data[ANGLE_W-1:0]);
                CFG_CLOSE_DELAY:  n_cfg.auto_close_delay  = i_cfg_data[TIMER_W-1:0];
                CFG_CLOSE_EN:     n_cfg.auto_close_enable = i_cfg_data[0];
                CFG_STEP_IVL:     n_cfg.step_interval     = i_cfg_data[STEP_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_angle        <= RST_OPEN_ANGLE;
            r_cfg.closed_angle      <= RST_CLOSED_ANGLE;
            r_cfg.auto_close_delay  <= RST_CLOSE_DELAY;
            r_cfg.auto_close_enable <= RST_CLOSE_EN;
            r_cfg.step_interval     <= RST_STEP_IVL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/sgsa_core.sv =====
module sgsa_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  sgsa_pkg::t_cmd    i_cmd,
    input  sgsa_pkg::t_cfg    i_cfg,
    output sgsa_pkg::t_result o_result
);
    import sgsa_pkg::*;

    logic [ANGLE_W-1:0] r_present, n_present;
    logic [ANGLE_W-1:0] r_goal, n_goal;
    logic               r_ramping, n_ramping;
    logic               r_opened, n_opened;
    logic               r_armed, n_armed;
    logic [TIMER_W-1:0] r_open_elapsed, n_open_elapsed;
    logic [STEP_W-1:0]  r_step_elapsed, n_step_elapsed;
    logic               written;
    logic               auto_fired;
    logic [STEP_W-1:0]  step_inc;
    logic [TIMER_W-1:0] open_inc;

    // saturating timer increments
    assign step_inc = (r_step_elapsed == STEP_MAX) ? r_step_elapsed
                                                   : r_step_elapsed + STEP_W'(1);
    assign open_inc = (r_open_elapsed == TIMER_MAX) ? r_open_elapsed
                                                    : r_open_elapsed + TIMER_W'(1);

    always_comb begin
        n_present      = r_present;
        n_goal         = r_goal;
        n_ramping      = r_ramping;
        n_opened       = r_opened;
        n_armed        = r_armed;
        n_open_elapsed = r_open_elapsed;
        n_step_elapsed = r_step_elapsed;
        written        = 1'b0;
        auto_fired     = 1'b0;
        case (t_op'(i_cmd.operation))
            OP_TICK: begin
                n_step_elapsed = step_inc;
                if (r_armed) begin
                    n_open_elapsed = open_inc;
                end
                if (!r_ramping) begin
                    if (i_cfg.auto_close_enable && r_opened && r_armed &&
                        n_open_elapsed >= i_cfg.auto_close_delay) begin
                        n_goal     = i_cfg.closed_angle;
                        n_ramping  = 1'b1;
                        n_opened   = 1'b0;
                        n_armed    = 1'b0;
                        auto_fired = 1'b1;
                    end
                end else if (step_inc >= i_cfg.step_interval) begin
                    n_step_elapsed = '0;
                    if (r_present < r_goal) begin
                        n_present = r_present + ANGLE_W'(1);
                        written   = 1'b1;
                    end else if (r_present > r_goal) begin
                        n_present = r_present - ANGLE_W'(1);
                        written   = 1'b1;
                    end else begin
                        n_ramping = 1'b0;
                    end
                end
            end
            OP_OPEN: begin
                if (!r_opened) begin
                    n_goal         = i_cfg.open_angle;
                    n_ramping      = 1'b1;
                    n_opened       = 1'b1;
                    n_armed        = 1'b1;
                    n_open_elapsed = '0;
                end
            end
            OP_CLOSE: begin
                if (r_opened) begin
                    n_goal    = i_cfg.closed_angle;
                    n_ramping = 1'b1;
                    n_opened  = 1'b0;
                    n_armed   = 1'b0;
                end
            end
            OP_MOVE: begin
                n_present = sat_angle(i_cmd.angle_request);
                n_ramping = 1'b0;
                written   = 1'b1;
            end
            OP_STOP: begin
                n_ramping = 1'b0;
                written   = 1'b1;
            end
            default: begin
                n_ramping = r_ramping;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present      <= RST_CLOSED_ANGLE;
            r_goal         <= RST_CLOSED_ANGLE;
            r_ramping      <= 1'b0;
            r_opened       <= 1'b0;
            r_armed        <= 1'b0;
            r_open_elapsed <= '0;
            r_step_elapsed <= STEP_MAX;
        end else if (i_en) begin
            r_present      <= n_present;
            r_goal         <= n_goal;
            r_ramping      <= n_ramping;
            r_opened       <= n_opened;
            r_armed        <= n_armed;
            r_open_elapsed <= n_open_elapsed;
            r_step_elapsed <= n_step_elapsed;
        end
    end

    always_comb begin
        o_result.servo_angle   = n_present;
        o_result.angle_written = written;
        o_result.gate_open     = n_opened;
        o_result.in_motion     = n_ramping;
        o_result.auto_closed   = auto_fired;
    end

endmodule

// ===== rtl/core/servo_gate_slew_autoclose_top.sv =====
// servo gate controller with slew-limited motion and auto-close. each command beat
// (tick, open, close, move to angle, stop) yields exactly one status beat holding the
// commanded servo angle, whether this beat wrote the servo, the open flag, the ramp flag
// and an auto-close marker. a beat passes through an input register, then one pass of
// compare/increment logic against the gate state into the result register, and one
// beat is taken every cycle while the result side keeps up; while a finished beat waits
// in the result register the input register still takes one more beat, after which the
// input stalls until the result side drains. config writes go to the register index
// given and are meant to happen only while no beat is in flight.
module servo_gate_slew_autoclose_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sgsa_cmd_if.sink                          i_cmd,
    sgsa_res_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [sgsa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sgsa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sgsa_pkg::*;

    t_cfg    cfg;
    t_result core_res;

    // input stage
    logic    r_s1_vld;
    t_cmd    r_s1_cmd;
    // result stage
    logic    r_out_vld;
    t_result r_out;

    logic    advance;   // input stage moves into the result register
    logic    in_take;   // command beat accepted

    sgsa_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // gate state only updates when the beat actually lands in the result register
    sgsa_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cmd    (r_s1_cmd),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    assign advance     = r_s1_vld && (!r_out_vld || o_res.ready);
    assign i_cmd.ready = !r_s1_vld || advance;
    assign in_take     = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_cmd.ready) begin
            r_s1_vld <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cmd.operation     <= i_cmd.operation;
            r_s1_cmd.angle_request <= i_cmd.angle_request;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.servo_angle   = r_out.servo_angle;
    assign o_res.angle_written = r_out.angle_written;
    assign o_res.gate_open     = r_out.gate_open;
    assign o_res.in_motion     = r_out.in_motion;
    assign o_res.auto_closed   = r_out.auto_closed;

`ifndef NO_ASSERTIONS
    // a beat leaving the input stage must show up in the result register
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("advanced beat did not reach result register");

    // auto-close starts a closing ramp
    a_auto_close_ramps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.auto_closed) |-> (r_out.in_motion && !r_out.gate_open))
        else $error("auto-close without closing ramp");

    // auto-close tick never also steps the servo
    a_auto_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.auto_closed && r_out.angle_written))
        else $error("auto-close and angle write in the same beat");

    // commanded angle stays in servo range
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.servo_angle <= MAX_ANGLE))
        else $error("servo angle out of range");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import sgsa_pkg::*;

    // spare operation codes, the block must report status and do nothing
    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int HOLD_CYCLES   = 80;    // long receiver hold-off
    localparam int STALL_LIMIT   = 4000;  // cycles with no beat on either side
    localparam int SETTLE_CYCLES = 4;     // input and result registers plus margin
    localparam int SHOW_MAX      = 40;    // mismatch lines printed

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    sgsa_cmd_if cmd_if ();
    sgsa_res_if res_if ();

    servo_gate_slew_autoclose_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // opening script: rows with a pinned status are compared against the typed value,
    // the rest against the gate model; flags are {written, open, motion, auto}
    typedef struct {
        logic [OP_W-1:0]    op;
        logic [ANGLE_W-1:0] req;
        bit                 pinned;
        logic [ANGLE_W-1:0] angle;
        logic [3:0]         flags;
    } t_script_row;

    t_script_row opening_script [21] = '{
        '{OP_TICK,   8'h00, 1'b1, 8'd0,   4'b0000},  // status right after reset
        '{OP_OPEN,   8'hFF, 1'b1, 8'd0,   4'b0110},  // ramp starts, nothing written yet
        '{OP_TICK,   8'h00, 1'b1, 8'd1,   4'b1110},  // saturated step timer: first step at once
        '{OP_TICK,   8'hFF, 1'b0, 8'd0,   4'b0000},  // too early for the next step
        '{OP_OPEN,   8'h00, 1'b0, 8'd0,   4'b0000},  // open while open is ignored
        '{OP_MOVE,   8'hFF, 1'b1, 8'd180, 4'b1100},  // request above range saturates
        '{OP_MOVE,   8'h00, 1'b1, 8'd0,   4'b1100},
        '{OP_MOVE,   8'd180, 1'b1, 8'd180, 4'b1100},
        '{OP_STOP,   8'h00, 1'b1, 8'd180, 4'b1100},  // stop rewrites the angle
        '{OP_CLOSE,  8'h00, 1'b1, 8'd180, 4'b0010},
        '{OP_CLOSE,  8'h00, 1'b0, 8'd0,   4'b0000},  // close while closed is ignored
        '{OP_TICK,   8'h00, 1'b0, 8'd0,   4'b0000},
        '{OP_SPARE5, 8'h55, 1'b0, 8'd0,   4'b0000},
        '{OP_SPARE6, 8'hAA, 1'b0, 8'd0,   4'b0000},
        '{OP_SPARE7, 8'hFF, 1'b0, 8'd0,   4'b0000},
        '{OP_MOVE,   8'd181, 1'b1, 8'd180, 4'b1000}, // just above range
        '{OP_MOVE,   8'h55, 1'b0, 8'd0,   4'b0000},
        '{OP_MOVE,   8'hAA, 1'b0, 8'd0,   4'b0000},
        '{OP_OPEN,   8'h0F, 1'b0, 8'd0,   4'b0000},
        '{OP_STOP,   8'hF0, 1'b0, 8'd0,   4'b0000},
        '{OP_CLOSE,  8'h00, 1'b0, 8'd0,   4'b0000}
    };

    // gate model: register copies
    logic [ANGLE_W-1:0] m_open_deg;
    logic [ANGLE_W-1:0] m_closed_deg;
    logic [TIMER_W-1:0] m_close_delay;
    logic               m_close_en;
    logic [STEP_W-1:0]  m_step_ivl;

    // gate model: state
    logic [ANGLE_W-1:0] cur_deg;
    logic [ANGLE_W-1:0] aim_deg;
    logic               slewing;
    logic               is_open;
    logic               timer_live;
    logic [TIMER_W-1:0] since_open;
    logic [STEP_W-1:0]  since_step;

    t_result status_q [$];     // status beats still owed by the block
    t_result pin_want;         // typed status that rides along with a script beat
    bit      pin_on;

    int  mismatches = 0;
    int  beats_out  = 0;
    int  beats_back = 0;
    int  idle_cycles = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;
    bit  hold_request = 1'b0;

    function automatic logic [ANGLE_W-1:0] limit_deg(input logic [ANGLE_W-1:0] a);
        return (a > 8'd180) ? 8'd180 : a;
    endfunction

    // advance the gate model by one command beat, return the status it reports
    function automatic t_result servo_status_after(input logic [OP_W-1:0] op,
                                                   input logic [ANGLE_W-1:0] req);
        t_result r;
        r = '0;
        case (op)
            OP_TICK: begin
                if (since_step != STEP_MAX) since_step = since_step + 1'b1;
                if (timer_live && since_open != TIMER_MAX) since_open = since_open + 1'b1;
                if (!slewing) begin
                    // auto-close only from rest
                    if (m_close_en && is_open && timer_live && since_open >= m_close_delay) begin
                        aim_deg    = m_closed_deg;
                        slewing    = 1'b1;
                        is_open    = 1'b0;
                        timer_live = 1'b0;
                        r.auto_closed = 1'b1;
                    end
                end else if (since_step >= m_step_ivl) begin
                    since_step = '0;
                    if (cur_deg < aim_deg) begin
                        cur_deg = cur_deg + 1'b1;
                        r.angle_written = 1'b1;
                    end else if (cur_deg > aim_deg) begin
                        cur_deg = cur_deg - 1'b1;
                        r.angle_written = 1'b1;
                    end else begin
                        slewing = 1'b0;   // arrival seen, ramp ends without a write
                    end
                end
            end
            OP_OPEN: begin
                if (!is_open) begin
                    aim_deg    = m_open_deg;
                    slewing    = 1'b1;
                    is_open    = 1'b1;
                    timer_live = 1'b1;
                    since_open = '0;
                end
            end
            OP_CLOSE: begin
                if (is_open) begin
                    aim_deg    = m_closed_deg;
                    slewing    = 1'b1;
                    is_open    = 1'b0;
                    timer_live = 1'b0;
                end
            end
            OP_MOVE: begin
                cur_deg = limit_deg(req);
                slewing = 1'b0;
                r.angle_written = 1'b1;
            end
            OP_STOP: begin
                slewing = 1'b0;
                r.angle_written = 1'b1;
            end
            default: ;
        endcase
        r.servo_angle = cur_deg;
        r.gate_open   = is_open;
        r.in_motion   = slewing;
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= SHOW_MAX)
            $display("tb_top: %s got %0d want %0d at status beat %0d",
                     what, got, want, beats_back);
    endtask

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // angle near one of the gate positions, or anywhere in the byte
    function automatic logic [ANGLE_W-1:0] pick_angle();
        int deg;
        if ($urandom_range(0, 9) < 4) return 8'($urandom);
        deg = $urandom_range(0, 1) ? int'(m_open_deg) : int'(m_closed_deg);
        deg = deg + int'($urandom_range(0, 8)) - 4;
        if (deg < 0) deg = 0;
        if (deg > 255) deg = 255;
        return 8'(deg);
    endfunction

    // length of a tick stretch, kept inside what is left of the quota
    function automatic int tick_count(input int target);
        int n;
        n = $urandom_range(0, 50);
        if (n > target - beats_out) n = target - beats_out;
        return (n < 0) ? 0 : n;
    endfunction

    // offer one command beat and hold it until taken
    task automatic offer(input logic [OP_W-1:0] op, input logic [ANGLE_W-1:0] req,
                         input bit pinned = 1'b0, input t_result want = '0);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.operation     <= op;
        cmd_if.angle_request <= req;
        pin_on               <= pinned;
        pin_want             <= want;
        do @(posedge i_clk); while (!cmd_if.ready);
        beats_out++;
    endtask

    // sender pauses until every owed status beat is back
    task automatic drain();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (status_q.size() != 0);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_OPEN_ANGLE:   m_open_deg    = limit_deg(val[ANGLE_W-1:0]);
            CFG_CLOSED_ANGLE: m_closed_deg  = limit_deg(val[ANGLE_W-1:0]);
            CFG_CLOSE_DELAY:  m_close_delay = val[TIMER_W-1:0];
            CFG_CLOSE_EN:     m_close_en    = val[0];
            CFG_STEP_IVL:     m_step_ivl    = val[STEP_W-1:0];
            default: ;
        endcase
    endtask

    // quiet the block, then load all five registers
    task automatic load_regs(input logic [CFG_DATA_W-1:0] open_v, closed_v, delay_v,
                             en_v, step_v);
        drain();
        set_reg(CFG_OPEN_ANGLE, open_v);
        set_reg(CFG_CLOSED_ANGLE, closed_v);
        set_reg(CFG_CLOSE_DELAY, delay_v);
        set_reg(CFG_CLOSE_EN, en_v);
        set_reg(CFG_STEP_IVL, step_v);
        cfg_we <= 1'b0;
    endtask

    // a stretch of ticks with an occasional stray command mixed in
    task automatic tick_run(input int n);
        repeat (n) begin
            if ($urandom_range(0, 99) < 7)
                offer(3'($urandom), pick_angle());
            else
                offer(OP_TICK, 8'($urandom));
        end
    endtask

    // mostly open/ramp/rest/close cycles, the rest loose noise
    task automatic gate_traffic(input int quota);
        int target;
        target = beats_out + quota;
        while (beats_out < target) begin
            if ($urandom_range(0, 9) < 8) begin
                offer(OP_OPEN, 8'($urandom));
                tick_run(tick_count(target));
                if ($urandom_range(0, 1)) begin
                    offer(OP_CLOSE, 8'($urandom));
                    tick_run(tick_count(target));
                end
            end else begin
                repeat ($urandom_range(1, 6)) offer(3'($urandom), pick_angle());
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = pick_gap(rx_calm);
                if (n > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end else begin
                    res_if.ready <= 1'b1;
                    @(posedge i_clk);
                end
            end
        end
    end

    // scoreboard: status beat out first, then the command beat taken at this edge
    always @(posedge i_clk) begin
        t_result got, want, pred;
        if (res_if.valid && res_if.ready) begin
            got = {res_if.servo_angle, res_if.angle_written, res_if.gate_open,
                   res_if.in_motion, res_if.auto_closed};
            if (status_q.size() == 0) begin
                report("status beat with nothing owed, angle", got.servo_angle, 0);
            end else begin
                want = status_q.pop_front();
                if (got.servo_angle != want.servo_angle)
                    report("servo_angle", got.servo_angle, want.servo_angle);
                if (got.angle_written != want.angle_written)
                    report("angle_written", got.angle_written, want.angle_written);
                if (got.gate_open != want.gate_open)
                    report("gate_open", got.gate_open, want.gate_open);
                if (got.in_motion != want.in_motion)
                    report("in_motion", got.in_motion, want.in_motion);
                if (got.auto_closed != want.auto_closed)
                    report("auto_closed", got.auto_closed, want.auto_closed);
            end
            beats_back++;
        end
        if (cmd_if.valid && cmd_if.ready) begin
            pred = servo_status_after(cmd_if.operation, cmd_if.angle_request);
            status_q.push_back(pin_on ? pin_want : pred);
        end
    end

    // watchdog on beats moving in either direction
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] open_v, closed_v, delay_v, en_v, step_v;
        int closed_deg, open_deg, r;

        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= '0;
        cfg_data             <= '0;
        cmd_if.valid         <= 1'b0;
        cmd_if.operation     <= OP_TICK;
        cmd_if.angle_request <= '0;
        pin_on               <= 1'b0;
        pin_want             <= '0;

        // model starts from the reset register values, closed and at rest
        m_open_deg    = RST_OPEN_ANGLE;
        m_closed_deg  = RST_CLOSED_ANGLE;
        m_close_delay = RST_CLOSE_DELAY;
        m_close_en    = RST_CLOSE_EN;
        m_step_ivl    = RST_STEP_IVL;
        cur_deg       = RST_CLOSED_ANGLE;
        aim_deg       = RST_CLOSED_ANGLE;
        slewing       = 1'b0;
        is_open       = 1'b0;
        timer_live    = 1'b0;
        since_open    = '0;
        since_step    = STEP_MAX;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // opening script on the reset settings
        foreach (opening_script[i])
            offer(opening_script[i].op, opening_script[i].req, opening_script[i].pinned,
                  t_result'({opening_script[i].angle, opening_script[i].flags}));

        // zero step interval and zero delay, full swing
        load_regs(24'd180, 24'd0, 24'd0, 24'd1, 24'd0);
        gate_traffic(120);

        // out-of-range open angle, slowest stepping, delay that never runs out; no idling
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        load_regs(24'd255, 24'd180, 24'hFFFFFF, 24'd1, 24'd255);
        gate_traffic(100);
        rx_calm = 1'b0;

        // receiver holds off while the sender keeps offering, auto-close disabled
        load_regs(24'd0, 24'd255, 24'd3, 24'd0, 24'd1);
        hold_request = 1'b1;
        gate_traffic(120);
        tx_calm = 1'b0;

        // open and closed at the same angle
        load_regs(24'd45, 24'd45, 24'd20, 24'd1, 24'd2);
        gate_traffic(120);

        // random settings, stray high bits on the narrow registers
        for (int p = 0; p < 11; p++) begin
            closed_deg = $urandom_range(0, 200);
            if ($urandom_range(0, 3) == 0) begin
                open_deg = $urandom_range(0, 255);
            end else begin
                open_deg = closed_deg + int'($urandom_range(0, 40)) - 20;
                if (open_deg < 0) open_deg = 0;
                if (open_deg > 255) open_deg = 255;
            end
            open_v   = {16'($urandom), 8'(open_deg)};
            closed_v = {16'($urandom), 8'(closed_deg)};
            r = $urandom_range(0, 99);
            if (r < 60)      delay_v = 24'($urandom_range(0, 40));
            else if (r < 85) delay_v = 24'($urandom_range(41, 400));
            else             delay_v = 24'($urandom);
            en_v = {23'($urandom), 1'($urandom_range(0, 3) != 0)};
            r = $urandom_range(0, 99);
            if (r < 70)      step_v = {16'($urandom), 8'($urandom_range(0, 3))};
            else if (r < 90) step_v = {16'($urandom), 8'($urandom_range(4, 20))};
            else             step_v = 24'($urandom);
            load_regs(open_v, closed_v, delay_v, en_v, step_v);
            gate_traffic(125);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (status_q.size() != 0)
            report("status beats never returned, count", 0, status_q.size());

        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sgsa_pkg.sv
rtl/core/sgsa_if.sv
rtl/core/sgsa_cfg_regs.sv
rtl/core/sgsa_core.sv
rtl/core/servo_gate_slew_autoclose_top.sv
tb/tb_top.sv
